/* rtl/dad_pkg.sv */
// ----------------------------------------------------------------------------
// dad_pkg: shared types and calendar helpers for the date shifter
// Field widths, status codes, controller states, command/status bundles,
// and the Gregorian month-length function.
// ----------------------------------------------------------------------------
package dad_pkg;

    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int OFFSET_BITS = 17;
    // Remaining-offset register carries one guard bit over the input offset
    localparam int REM_W       = OFFSET_BITS + 1;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  FIRST_YEAR = YEAR_W'(1);
    localparam logic [MONTH_W-1:0] JANUARY    = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER   = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   LONG_MONTH = DAY_W'(31);

    // y / 100 as (y * 5243) >> 19, exact for every 14-bit y
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = YEAR_W + 13;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_DATE = 2'd1,
        STAT_RANGE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    publish;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_date;
        logic walk_done;
        logic range_hit;
    } t_dp_sts;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [YEAR_W-1:0] q;
        logic [YEAR_W-1:0] rem;
        prod = PROD_W'(y) * PROD_W'(DIV100_MUL);
        q    = YEAR_W'(prod >> DIV100_SHIFT);
        rem  = y - YEAR_W'(q * YEAR_W'(100));
        return (y[1:0] == 2'b00) && ((rem != '0) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0]  y,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
            len = DAY_W'(31);
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = DAY_W'(30);
        end else if (m == FEBRUARY) begin
            len = is_leap(y) ? DAY_W'(29) : DAY_W'(28);
        end else begin
            len = '0;
        end
        return len;
    endfunction

endpackage

/* rtl/dad_ctrl.sv */
// ----------------------------------------------------------------------------
// dad_ctrl: sequencer for the date shifter
// Accepts a beat, runs check and month walk in the datapath, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module dad_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dad_pkg::t_dp_cmd  o_cmd,
    input  dad_pkg::t_dp_sts  i_sts
);
    import dad_pkg::*;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_out_valid, n_out_valid;
    logic    slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_code      <= STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_code        = r_code;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_cmd         = '0;
        o_cmd.code    = r_code;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.bad_date) begin
                    n_code  = STAT_BAD_DATE;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_code  = STAT_OK;
                    n_state = ST_FINISH;
                end else if (i_sts.range_hit) begin
                    n_code  = STAT_RANGE;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CHECK))
        else $error("accepted beat did not start the check");

    a_done_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && i_sts.walk_done) |=> (r_state == ST_FINISH && r_code == STAT_OK))
        else $error("finished walk did not report ok");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_out_valid || i_out_ready))
        else $error("result published over a pending beat");

endmodule

/* rtl/dad_datapath.sv */
// ----------------------------------------------------------------------------
// dad_datapath: date registers, month-walk step and result register
// Holds the working date and remaining offset; each step moves by up to the
// rest of the current month.
// ----------------------------------------------------------------------------
module dad_datapath (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [dad_pkg::YEAR_W-1:0]                 i_start_year,
    input  logic [dad_pkg::MONTH_W-1:0]                i_start_month,
    input  logic [dad_pkg::DAY_W-1:0]                  i_start_day,
    input  logic signed [dad_pkg::OFFSET_BITS-1:0]     i_day_offset,
    input  dad_pkg::t_dp_cmd                           i_cmd,
    output dad_pkg::t_dp_sts                           o_sts,
    output logic [dad_pkg::YEAR_W-1:0]                 o_result_year,
    output logic [dad_pkg::MONTH_W-1:0]                o_result_month,
    output logic [dad_pkg::DAY_W-1:0]                  o_result_day,
    output logic [dad_pkg::STATUS_W-1:0]               o_status
);
    import dad_pkg::*;

    logic [YEAR_W-1:0]   r_year, n_year;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [YEAR_W-1:0]   r_res_year;
    logic [MONTH_W-1:0]  r_res_month;
    logic [DAY_W-1:0]    r_res_day;
    logic [STATUS_W-1:0] r_res_status;

    logic [DAY_W-1:0]    len;
    logic [DAY_W-1:0]    prev_len;
    logic [DAY_W-1:0]    gap;
    logic [REM_W-1:0]    gap_ext;
    logic [REM_W-1:0]    day_ext;
    logic [REM_W-1:0]    neg_mag;
    logic                forward;
    logic                fits;
    logic                at_top;
    logic                at_bottom;

    assign len      = month_days(r_year, r_month);
    assign prev_len = (r_month == JANUARY) ? LONG_MONTH
                                           : month_days(r_year, r_month - MONTH_W'(1));
    assign gap      = len - r_day;
    assign gap_ext  = REM_W'(gap);
    assign day_ext  = REM_W'(r_day);
    assign neg_mag  = '0 - r_rem;
    assign forward  = !r_rem[REM_W-1];
    assign fits     = forward ? (r_rem <= gap_ext) : (neg_mag < day_ext);
    assign at_top    = (r_year == MAX_YEAR) && (r_month == DECEMBER);
    assign at_bottom = (r_year == FIRST_YEAR) && (r_month == JANUARY);

    assign o_sts.walk_done = (r_rem == '0);
    assign o_sts.range_hit = !fits && (forward ? at_top : at_bottom);
    assign o_sts.bad_date  = (r_year == '0) || (r_year > MAX_YEAR) || (r_day == '0)
                             || (r_day > len);

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_rem   = r_rem;
        if (i_cmd.load) begin
            n_year  = i_start_year;
            n_month = i_start_month;
            n_day   = i_start_day;
            n_rem   = {{(REM_W-OFFSET_BITS){i_day_offset[OFFSET_BITS-1]}}, i_day_offset};
        end else if (i_cmd.step) begin
            if (fits) begin
                // land inside the current month
                n_day = r_day + r_rem[DAY_W-1:0];
                n_rem = '0;
            end else if (forward) begin
                // advance to the first of the next month
                n_rem = r_rem - gap_ext - REM_W'(1);
                n_day = DAY_W'(1);
                if (r_month == DECEMBER) begin
                    n_month = JANUARY;
                    n_year  = r_year + YEAR_W'(1);
                end else begin
                    n_month = r_month + MONTH_W'(1);
                end
            end else begin
                // back up to the last day of the previous month
                n_rem = r_rem + day_ext;
                n_day = prev_len;
                if (r_month == JANUARY) begin
                    n_month = DECEMBER;
                    n_year  = r_year - YEAR_W'(1);
                end else begin
                    n_month = r_month - MONTH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_rem   <= n_rem;
        if (i_cmd.publish) begin
            r_res_status <= i_cmd.code;
            if (i_cmd.code == STAT_OK) begin
                r_res_year  <= r_year;
                r_res_month <= r_month;
                r_res_day   <= r_day;
            end else begin
                r_res_year  <= '0;
                r_res_month <= '0;
                r_res_day   <= '0;
            end
        end
    end

    assign o_result_year  = r_res_year;
    assign o_result_month = r_res_month;
    assign o_result_day   = r_res_day;
    assign o_status       = r_res_status;

    a_error_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.publish && i_cmd.code != STAT_OK)
        |=> (r_res_year == '0 && r_res_month == '0 && r_res_day == '0))
        else $error("error result carries a nonzero date");

    a_fit_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && fits) |=> (r_rem == '0))
        else $error("step inside the month left days over");

    a_step_toward_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !fits && forward) |=> !r_rem[REM_W-1])
        else $error("forward step overshot past zero");

endmodule

/* rtl/date_add_days_unit.sv */
// ----------------------------------------------------------------------------
// date_add_days_unit: Gregorian date plus signed day offset
// Walks month by month from the start date to the shifted date, flags
// invalid start dates and results outside years 1 to MAX_YEAR.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat is loaded and checked, then walked month by month
//   until the remaining offset lands inside a month, at most about 2150 month
//   boundaries for a 65535-day offset; a zero offset needs no step, a result
//   leaving the year range stops the walk, and an invalid start date goes from
//   the check straight to the finish state, which publishes the result.
// Throughput: the input stays closed until the result is published; the month
//   walk moves one month per cycle, and output stalls hold the finish state.
// Reset: synchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module date_add_days_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [dad_pkg::YEAR_W-1:0]              i_start_year,
    input  logic [dad_pkg::MONTH_W-1:0]             i_start_month,
    input  logic [dad_pkg::DAY_W-1:0]               i_start_day,
    input  logic signed [dad_pkg::OFFSET_BITS-1:0]  i_day_offset,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [dad_pkg::YEAR_W-1:0]              o_result_year,
    output logic [dad_pkg::MONTH_W-1:0]             o_result_month,
    output logic [dad_pkg::DAY_W-1:0]               o_result_day,
    output logic [dad_pkg::STATUS_W-1:0]            o_status
);
    import dad_pkg::*;

    // Command bundle from the sequencer, status bundle back from the datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: idle -> check -> walk -> finish; the result register lets
    // a new beat enter once the finished one has been handed over.
    dad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath: working date, remaining offset and the result register
    dad_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_year   (i_start_year),
        .i_start_month  (i_start_month),
        .i_start_day    (i_start_day),
        .i_day_offset   (i_day_offset),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_year  (o_result_year),
        .o_result_month (o_result_month),
        .o_result_day   (o_result_day),
        .o_status       (o_status)
    );

endmodule
